FILE: rtl/core/fdl_pkg.sv
// Package for the linear-interpolated fractional delay line.
// Holds field widths, the tap flag struct and queue sizing.
// No dependencies.
package fdl_pkg;

	localparam int SAMPLE_W = 24;
	localparam int DELAY_W  = 26;
	localparam int DIFF_W   = SAMPLE_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic fwd;   // tap 1 is the sample written by this word
		logic v1;    // tap 1 holds written data
		logic v2;    // tap 2 holds written data
	} tap_flags_t;

endpackage

FILE: rtl/core/fdl_front.sv
// Front end: write pointer, fill count, delay clamp and tap addressing.
// Depends on fdl_pkg.
module fdl_front #(
	parameter int DEPTH     = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [fdl_pkg::DELAY_W-1:0]        delay_amount,
	output logic                               cmd_valid,
	input  logic                               cmd_ready,
	output logic signed [fdl_pkg::SAMPLE_W-1:0] cmd_sample,
	output logic [FRAC_BITS-1:0]               cmd_frac,
	output logic [$clog2(DEPTH)-1:0]           cmd_wr_addr,
	output logic [$clog2(DEPTH)-1:0]           cmd_rd_addr1,
	output logic [$clog2(DEPTH)-1:0]           cmd_rd_addr2,
	output fdl_pkg::tap_flags_t                cmd_flags
);
	import fdl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int IW = DELAY_W - FRAC_BITS;
	localparam int CW = (IW > AW) ? IW : AW;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [AW-1:0] MAX_I   = AW'(DEPTH - 2);
	localparam logic [CW-1:0] MAX_I_W = CW'(DEPTH - 2);

	logic [AW-1:0] ptr_q;
	logic [AW:0]   fill_q;
	logic [CW-1:0] ipart;
	logic [AW-1:0] ipart_cl;
	logic [AW:0]   dif;
	logic [AW:0]   wrapped;
	logic [AW-1:0] idx1;
	logic          push;

	assign push = item_valid && cmd_ready;

	always_comb begin
		ipart    = CW'(delay_amount >> FRAC_BITS);
		ipart_cl = (ipart > MAX_I_W) ? MAX_I : ipart[AW-1:0];
		dif      = {1'b0, ptr_q} - {1'b0, ipart_cl};
		wrapped  = dif + DEPTH_W;
		idx1     = dif[AW] ? wrapped[AW-1:0] : dif[AW-1:0];
	end

	assign item_ready    = cmd_ready;
	assign cmd_valid     = item_valid;
	assign cmd_sample    = sample_in;
	assign cmd_frac      = delay_amount[FRAC_BITS-1:0];
	assign cmd_wr_addr   = ptr_q;
	assign cmd_rd_addr1  = idx1;
	assign cmd_rd_addr2  = (idx1 == '0) ? LAST : idx1 - 1'b1;
	assign cmd_flags.fwd = (ipart_cl == '0);
	assign cmd_flags.v1  = ({1'b0, ipart_cl} <= fill_q);
	assign cmd_flags.v2  = ({1'b0, ipart_cl} < fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (push) begin
			ptr_q <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
			if (fill_q != DEPTH_W) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/fdl_queue.sv
// Two-entry queue between the front end and the interpolation back end.
// Depends on fdl_pkg.
module fdl_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import fdl_pkg::*;

	localparam logic [QUEUE_AW:0] FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);

	logic [WIDTH-1:0]    entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/fdl_back.sv
// Back end: sample ring memory, tap select, interpolation multiply, rounding.
// Depends on fdl_pkg.
module fdl_back #(
	parameter int DEPTH     = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic signed [fdl_pkg::SAMPLE_W-1:0] cmd_sample,
	input  logic [FRAC_BITS-1:0]               cmd_frac,
	input  logic [$clog2(DEPTH)-1:0]           cmd_wr_addr,
	input  logic [$clog2(DEPTH)-1:0]           cmd_rd_addr1,
	input  logic [$clog2(DEPTH)-1:0]           cmd_rd_addr2,
	input  fdl_pkg::tap_flags_t                cmd_flags,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [fdl_pkg::SAMPLE_W-1:0] sample_out
);
	import fdl_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = DIFF_W + FRAC_BITS + 1;
	localparam int ACC_W = FRAC_BITS + SAMPLE_W + 3;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	logic                       v_s1, v_s2, v_s3, out_v_q;
	logic                       adv1, adv2, adv3, adv_o, pop;
	logic signed [SAMPLE_W-1:0] rd1_s1, rd2_s1, x_s1;
	logic [FRAC_BITS-1:0]       frac_s1, frac_s2;
	tap_flags_t                 flags_s1;
	logic signed [SAMPLE_W-1:0] y1, y2;
	logic signed [SAMPLE_W-1:0] y1_s2, y1_s3;
	logic signed [DIFF_W-1:0]   diff_s2;
	logic signed [FRAC_BITS:0]  frac_sx;
	logic signed [PW-1:0]       prod_s3;
	logic signed [ACC_W-1:0]    acc;
	logic signed [SAMPLE_W-1:0] out_q;

	assign adv_o     = !out_v_q || result_ready;
	assign adv3      = !v_s3 || adv_o;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign cmd_ready = adv1;
	assign pop       = cmd_valid && adv1;

	always_comb begin
		y1      = flags_s1.fwd ? x_s1 : (flags_s1.v1 ? rd1_s1 : '0);
		y2      = flags_s1.v2 ? rd2_s1 : '0;
		frac_sx = $signed({1'b0, frac_s2});
		acc     = (ACC_W'(y1_s3) <<< FRAC_BITS) + ACC_W'(prod_s3) + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pop;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv_o) out_v_q <= v_s3;
		end
	end

	// ring memory: one write and two registered reads per word
	always_ff @(posedge clk) begin
		if (pop) begin
			mem[cmd_wr_addr] <= cmd_sample;
			rd1_s1           <= mem[cmd_rd_addr1];
			rd2_s1           <= mem[cmd_rd_addr2];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1     <= cmd_sample;
			frac_s1  <= cmd_frac;
			flags_s1 <= cmd_flags;
		end
		if (adv2 && v_s1) begin
			y1_s2   <= y1;
			diff_s2 <= DIFF_W'(y2) - DIFF_W'(y1);
			frac_s2 <= frac_s1;
		end
		if (adv3 && v_s2) begin
			y1_s3   <= y1_s2;
			prod_s3 <= PW'(diff_s2) * PW'(frac_sx);
		end
		if (adv_o && v_s3) begin
			out_q <= acc[FRAC_BITS +: SAMPLE_W];
		end
	end

	assign result_valid = out_v_q;
	assign sample_out   = out_q;

`ifndef SYNTH
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd_flags.fwd |-> cmd_flags.v1)
		else $error("forwarded tap not marked valid");
	a_tap_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd_flags.v2 |-> cmd_flags.v1)
		else $error("older tap valid while newer tap is not");
	a_tap_adj: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ((cmd_rd_addr1 == '0 && cmd_rd_addr2 == LAST) ||
			(cmd_rd_addr1 != '0 && cmd_rd_addr2 == cmd_rd_addr1 - 1'b1)))
		else $error("taps not adjacent");
	a_fwd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd_flags.fwd |-> cmd_rd_addr1 == cmd_wr_addr)
		else $error("forward flag on foreign address");
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv_o |=> v_s3 && $stable(prod_s3))
		else $error("stalled product stage lost its word");
`endif

endmodule

FILE: rtl/core/fractional_delay_line_linear_interp_core.sv
// Top level of the linear-interpolated fractional delay line.
// Depends on fdl_pkg, fdl_front, fdl_queue and fdl_back.
//
//   channel   handshake                   payload
//   input     item_valid / item_ready     sample_in, delay_amount
//   output    result_valid / result_ready sample_out
//
// One word per cycle sustained while result_ready holds; an accepted word reaches result_valid
// through the queue, memory read, tap select, multiply and rounding registers.
// The ring memory's single write port and two read ports set the one-per-cycle rate.
// Reset clears pointer, fill count and pipeline valids; no memory clearing pass,
// taps beyond the fill count read as zero.
// Output stalls back up through the pipeline into the two-entry queue.
module fractional_delay_line_linear_interp_core #(
	parameter int DEPTH     = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [fdl_pkg::DELAY_W-1:0]        delay_amount,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [fdl_pkg::SAMPLE_W-1:0] sample_out
);
	import fdl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $bits(tap_flags_t);
	localparam int QW = SAMPLE_W + FRAC_BITS + 3 * AW + FW;

	logic                       f_valid, f_ready;
	logic signed [SAMPLE_W-1:0] f_sample;
	logic [FRAC_BITS-1:0]       f_frac;
	logic [AW-1:0]              f_wa, f_ra1, f_ra2;
	tap_flags_t                 f_flags;

	logic                       b_valid, b_ready;
	logic [QW-1:0]              b_data;
	logic signed [SAMPLE_W-1:0] b_sample;
	logic [FRAC_BITS-1:0]       b_frac;
	logic [AW-1:0]              b_wa, b_ra1, b_ra2;
	tap_flags_t                 b_flags;

	fdl_front #(
		.DEPTH     (DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.sample_in    (sample_in),
		.delay_amount (delay_amount),
		.cmd_valid    (f_valid),
		.cmd_ready    (f_ready),
		.cmd_sample   (f_sample),
		.cmd_frac     (f_frac),
		.cmd_wr_addr  (f_wa),
		.cmd_rd_addr1 (f_ra1),
		.cmd_rd_addr2 (f_ra2),
		.cmd_flags    (f_flags)
	);

	fdl_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_sample, f_frac, f_wa, f_ra1, f_ra2, f_flags}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	assign {b_sample, b_frac, b_wa, b_ra1, b_ra2, b_flags} = b_data;

	fdl_back #(
		.DEPTH     (DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (b_valid),
		.cmd_ready    (b_ready),
		.cmd_sample   (b_sample),
		.cmd_frac     (b_frac),
		.cmd_wr_addr  (b_wa),
		.cmd_rd_addr1 (b_ra1),
		.cmd_rd_addr2 (b_ra2),
		.cmd_flags    (b_flags),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_out   (sample_out)
	);

endmodule

FILE: tb/tb_fractional_delay_line_linear_interp_core.sv
// Testbench for fractional_delay_line_linear_interp_core: drives words through a
// valid/ready driver and checks every result against a built-in ring-buffer predictor.
// Depends on fdl_pkg and the core RTL.
module tb_fractional_delay_line_linear_interp_core;
	timeunit 1ns;
	timeprecision 1ps;
	import fdl_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int N_RANDOM    = 1900;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD   = 150;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic [DELAY_W-1:0]         dly;
		int                         gap;
		bit                         drain;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [DELAY_W-1:0] delay_amount = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;

	word_t pend_q[$];
	logic signed [SAMPLE_W-1:0] expected_out_q[$];
	logic signed [SAMPLE_W-1:0] ring[DEPTH];
	int wr_ptr;
	int n_written;
	int n_checked;
	int n_clamped;
	int n_early;
	int n_drains;
	int err_cnt;
	int idle_cycles;

	fractional_delay_line_linear_interp_core #(
		.DEPTH(DEPTH),
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sample_in(sample_in),
		.delay_amount(delay_amount),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample_out(sample_out)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		if (err_cnt < 20)
			$display("MISMATCH result %0d: %s got %h want %h", n_checked, what, got, want);
		err_cnt++;
	endtask

	// write one sample, then interpolate between the two taps at the requested delay
	function automatic logic signed [SAMPLE_W-1:0] delay_line_step(
			input logic signed [SAMPLE_W-1:0] smp, input logic [DELAY_W-1:0] dly);
		int p;
		int whole;
		int i1;
		int i2;
		longint y1;
		longint y2;
		longint f;
		longint acc;
		p = wr_ptr;
		ring[p] = smp;
		wr_ptr = (p + 1) % DEPTH;
		n_written++;
		whole = int'(dly >> FRAC_BITS);
		if (whole > DEPTH - 2) begin
			whole = DEPTH - 2;
			n_clamped++;
		end
		if (whole + 2 > n_written)
			n_early++;
		f = longint'(dly[FRAC_BITS-1:0]);
		i1 = (p + DEPTH - whole) % DEPTH;
		i2 = (p + DEPTH - whole - 1) % DEPTH;
		y1 = longint'(ring[i1]);
		y2 = longint'(ring[i2]);
		acc = y1 * (longint'(1) << FRAC_BITS) + (y2 - y1) * f
			+ (longint'(1) << (FRAC_BITS - 1));
		acc = acc >>> FRAC_BITS;
		return acc[SAMPLE_W-1:0];
	endfunction

	function automatic logic [DELAY_W-1:0] mk_delay(input int whole, input int frac);
		return (DELAY_W'(whole) << FRAC_BITS) | DELAY_W'(frac);
	endfunction

	task automatic add_word(input logic signed [SAMPLE_W-1:0] smp, input logic [DELAY_W-1:0] dly,
			input int gap, input bit drain);
		word_t w;
		w.smp = smp;
		w.dly = dly;
		w.gap = gap;
		w.drain = drain;
		pend_q.push_back(w);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		int gap_cnt;
		bit just_took;
		word_t cur;
		if (!arst_n) begin
			item_valid <= 1'b0;
			sample_in <= '0;
			delay_amount <= '0;
			gap_cnt = 0;
		end else begin
			just_took = item_valid && item_ready;
			if (item_valid && !item_ready) begin
			end else if (pend_q.size() == 0) begin
				item_valid <= 1'b0;
			end else if (gap_cnt < pend_q[0].gap) begin
				gap_cnt++;
				item_valid <= 1'b0;
			end else if (pend_q[0].drain && (just_took || expected_out_q.size() != 0)) begin
				item_valid <= 1'b0;
			end else begin
				cur = pend_q.pop_front();
				if (cur.drain)
					n_drains++;
				item_valid <= 1'b1;
				sample_in <= cur.smp;
				delay_amount <= cur.dly;
				gap_cnt = 0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		int rx_wait;
		int rx_cnt;
		bit calm;
		bit held;
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait = 0;
			rx_cnt = 0;
			calm = 1'b0;
			held = 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				rx_cnt++;
				if (rx_cnt % 64 == 0)
					calm = ($urandom_range(0, 2) == 0);
				if (!held && rx_cnt >= 500) begin
					rx_wait = LONG_HOLD;
					held = 1'b1;
				end else begin
					rx_wait = calm ? 0 : $urandom_range(0, 17);
				end
			end
			if (rx_wait > 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// monitor: predict accepted words first, then check accepted results
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (item_valid && item_ready)
				expected_out_q.push_back(delay_line_step(sample_in, delay_amount));
			if (result_valid && result_ready) begin
				if (expected_out_q.size() == 0) begin
					report_mismatch("unexpected sample_out", sample_out, '0);
				end else begin
					want = expected_out_q.pop_front();
					if (sample_out !== want)
						report_mismatch("sample_out", sample_out, want);
				end
				n_checked++;
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] smp;
		logic [DELAY_W-1:0] dly;
		int gap_mode;
		int gap;
		int r;
		int whole;

		// the store starts out cleared, as the core reads unwritten taps as zero after reset
		foreach (ring[k])
			ring[k] = '0;

		// directed words: extremes, clamp, taps into unwritten history, rounding ties
		add_word(24'sh7FFFFF, mk_delay(0, 0), 0, 0);
		add_word(-24'sh800000, mk_delay(0, 0), 0, 0);
		add_word(24'sd123, mk_delay(DEPTH - 2, 16'hFFFF), 0, 0);
		add_word(-24'sd1, mk_delay(DEPTH - 1, 0), 0, 0);
		add_word(24'sh7FFFFF, mk_delay(0, 16'h8000), 0, 0);
		add_word(-24'sh800000, mk_delay(0, 16'h8000), 0, 0);
		add_word(-24'sh800000, mk_delay(1, 16'h8000), 0, 0);
		add_word(24'sd0, mk_delay(1, 16'hFFFF), 1, 0);
		add_word(24'sd1, mk_delay(0, 16'h8000), 0, 0);
		add_word(24'sd2, mk_delay(0, 16'h8000), 0, 0);
		add_word(-24'sd3, mk_delay(1, 16'h8000), 3, 0);
		add_word(24'sh555555, mk_delay(2, 16'h0001), 0, 0);
		add_word(-24'sh2AAAAB, mk_delay(5, 16'h7FFF), 0, 0);
		add_word(24'sh7FFFFF, mk_delay(0, 16'hFFFF), 0, 0);
		add_word(-24'sh800000, mk_delay(0, 16'hFFFF), 0, 0);
		add_word(24'sh7FFFFF, mk_delay(DEPTH - 2, 0), 0, 0);
		add_word(24'sh000001, mk_delay(DEPTH - 3, 16'hAAAA), 2, 0);
		add_word(-24'sh000001, mk_delay(12, 16'h5555), 0, 1);
		add_word(24'sh123456, mk_delay(DEPTH - 1, 0), 0, 0);
		add_word(-24'sh654321, mk_delay(3, 16'h8000), 0, 0);

		gap_mode = 1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0)
				gap_mode = $urandom_range(0, 2);
			r = $urandom_range(0, 7);
			if (r == 0)
				smp = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : -24'sh800000;
			else if (r == 1)
				smp = ($urandom_range(0, 1) != 0) ? 24'sd0 : -24'sd1;
			else
				smp = SAMPLE_W'($urandom());
			r = $urandom_range(0, 15);
			whole = $urandom_range(0, DEPTH - 2);
			if (r == 10)
				dly = mk_delay($urandom_range(0, 3), $urandom_range(0, 16'hFFFF));
			else if (r == 11)
				dly = mk_delay($urandom_range(DEPTH - 4, DEPTH - 2), $urandom_range(0, 16'hFFFF));
			else if (r == 12)
				dly = mk_delay(DEPTH - 1, 0);
			else if (r == 13)
				dly = mk_delay(whole, (($urandom_range(0, 2) == 0) ? 0 :
					($urandom_range(0, 1) != 0) ? 16'h8000 : 16'hFFFF));
			else if (r == 14)
				dly = '0;
			else
				dly = mk_delay(whole, $urandom_range(0, 16'hFFFF));
			if (i >= 450 && i < 750)
				gap = 0;
			else if (gap_mode == 0)
				gap = 0;
			else if (gap_mode == 1)
				gap = $urandom_range(0, 17);
			else
				gap = $urandom_range(0, 3);
			add_word(smp, dly, gap, (i % 317 == 100));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_out_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_out_q.size() != 0)
			report_mismatch("results missing at end", '0, '0);
		$display("Sent %0d words and checked %0d results, %0d with a clamped delay,",
			n_written, n_checked, n_clamped);
		$display("%0d reading unwritten history, %0d pauses until the pipeline drained.",
			n_early, n_drains);
		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/fdl_pkg.sv
rtl/core/fdl_front.sv
rtl/core/fdl_queue.sv
rtl/core/fdl_back.sv
rtl/core/fractional_delay_line_linear_interp_core.sv
tb/tb_fractional_delay_line_linear_interp_core.sv
